// ----- rtl/wtoc_pkg.sv -----
// ----------------------------------------------------------------------------
// wtoc_pkg
// Shared types and constants of the wavetable oscillator with crossfade.
// ----------------------------------------------------------------------------
`default_nettype none

package wtoc_pkg;

  localparam int TABLE_BITS_DEF  = 11;
  localparam int TABLE_COUNT_DEF = 8;

  localparam int SAMPLE_W  = 16;
  localparam int FADE_W    = 17;
  localparam int STEP_W    = 18;
  localparam int PHASE_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int ADDR_IN_W = 11;
  localparam int SEL_W     = 3;
  localparam int MODE_W    = 2;

  localparam logic [FADE_W-1:0] FADE_ONE = 17'h10000;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHIRP_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE1_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FADE1_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FADE2_STEP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FADE3_STEP  = 3'd6;

  // request to the shared blend unit: x + floor((y - x) * f / 2^16)
  typedef struct packed {
    logic                       start;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic        [FADE_W-1:0]   f;
  } blend_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] value;
  } blend_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/wavetable_oscillator_crossfade.sv -----
// ----------------------------------------------------------------------------
// wavetable_oscillator_crossfade
// Chirping phase accumulator, linear table interpolation, 0..3 crossfades.
// ----------------------------------------------------------------------------
// A sample word (mode 0) reads two neighboring entries from each active
// table (1, 2, 4 or 8 tables for dimensions 0..3) and blends them with the
// 16-bit phase fraction, then crossfades the table values pairwise (dim 3,
// then 2, then 1). Every blend goes through one shared three-stage
// multiply unit driven by a small sequencer, and the block holds in_stall
// high until the sample is in the output register. A sample word runs two
// table reads and a blend for each of the 2^dimensions tables, then two
// operand fetches and a blend for each crossfade, and it waits in S_OUT
// while the previous sample still sits unclaimed in the output register.
// Table writes (mode 1), restarts (mode 2) and mode 3 leave in_stall low
// and give no output word. Table entries must be written before they are
// read; there is no clearing pass. Configuration writes are taken any
// cycle but must only happen while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_oscillator_crossfade #(
  parameter int TABLE_BITS  = wtoc_pkg::TABLE_BITS_DEF,
  parameter int TABLE_COUNT = wtoc_pkg::TABLE_COUNT_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // input words
  input  wire logic                                  in_valid,
  output      logic                                  in_stall,
  input  wire logic [wtoc_pkg::MODE_W-1:0]           mode,
  input  wire logic [wtoc_pkg::SEL_W-1:0]            table_select,
  input  wire logic [wtoc_pkg::ADDR_IN_W-1:0]        table_address,
  input  wire logic signed [wtoc_pkg::SAMPLE_W-1:0]  table_value,
  // output words
  output      logic                                  out_valid,
  input  wire logic                                  out_stall,
  output      logic signed [wtoc_pkg::SAMPLE_W-1:0]  sample,
  // configuration
  input  wire logic                                  cfg_we,
  input  wire logic [wtoc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [wtoc_pkg::CFG_W-1:0]            cfg_data
);
  import wtoc_pkg::*;

  localparam int FRAC_SHIFT = 16 - TABLE_BITS;
  localparam int TSEL_W     = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int ADDR_W     = TSEL_W + TABLE_BITS;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD_A  = 4'd1;  // read entry at idx0
  localparam logic [3:0] S_RD_B  = 4'd2;  // read entry at idx1, latch a
  localparam logic [3:0] S_RD_W  = 4'd3;  // start interpolation
  localparam logic [3:0] S_IWAIT = 4'd4;
  localparam logic [3:0] S_XA    = 4'd5;  // fetch first crossfade operand
  localparam logic [3:0] S_XB    = 4'd6;  // start crossfade
  localparam logic [3:0] S_XWAIT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  // configuration registers
  logic [1:0]         dimensions;
  logic [PHASE_W-1:0] start_phase_step;
  logic [PHASE_W-1:0] chirp_step;
  logic [FADE_W-1:0]  fade1_start;
  logic [STEP_W-1:0]  fade1_step;
  logic [STEP_W-1:0]  fade2_step;
  logic [STEP_W-1:0]  fade3_step;

  // oscillator state
  logic [PHASE_W-1:0] phase_acc;
  logic [PHASE_W-1:0] phase_step;
  logic [FADE_W-1:0]  fade1;
  logic [FADE_W-1:0]  fade2;
  logic [FADE_W-1:0]  fade3;

  // sequencer
  logic [3:0]                 state;
  logic [2:0]                 t;       // table being interpolated
  logic [1:0]                 stage;   // crossfade dimension in progress
  logic [1:0]                 p;       // pair within the stage
  logic signed [SAMPLE_W-1:0] v [8];   // per-table values
  logic signed [SAMPLE_W-1:0] opx;

  logic                       in_acc;
  logic                       out_free;
  logic [TABLE_BITS-1:0]      idx0;
  logic [TABLE_BITS-1:0]      idx1;
  logic [FADE_W-1:0]          frac;
  logic [2:0]                 n_last;
  logic [2:0]                 half;
  logic [1:0]                 half_last;
  logic                       t_ok;
  logic [2:0]                 v_idx;
  logic signed [SAMPLE_W-1:0] v_rd;
  logic [FADE_W-1:0]          fade_sel;

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic                       mem_re;
  logic [ADDR_W-1:0]          mem_raddr;
  logic signed [SAMPLE_W-1:0] mem_rdata;
  logic [TABLE_BITS-1:0]      wr_idx;

  blend_req_t                 breq;
  blend_rsp_t                 brsp;

  function automatic logic [FADE_W-1:0] fade_advance(input logic [FADE_W-1:0] f,
                                                     input logic [STEP_W-1:0] step);
    logic signed [STEP_W:0] sum;
    sum = $signed({2'b00, f}) + $signed({step[STEP_W-1], step});
    if (sum < 0) begin
      return '0;
    end else if (sum > $signed({2'b00, FADE_ONE})) begin
      return FADE_ONE;
    end else begin
      return sum[FADE_W-1:0];
    end
  endfunction

  assign in_stall = rst || (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // top bits pick the entry, the next 16 form the interpolation fraction
  assign idx0 = phase_acc[PHASE_W-1 -: TABLE_BITS];
  assign idx1 = idx0 + 1'b1;
  assign frac = {1'b0, phase_acc[FRAC_SHIFT +: 16]};

  assign n_last    = 3'(({1'b0, 3'b001} << dimensions) - 4'd1);
  assign half      = 3'(3'b001 << (stage - 2'd1));
  assign half_last = 2'(half - 3'd1);
  // tables beyond TABLE_COUNT read as zero
  assign t_ok      = (t < TABLE_COUNT);

  // one read of the value bank per cycle
  assign v_idx = (state == S_XB) ? ({1'b0, p} + half) : {1'b0, p};
  assign v_rd  = v[v_idx];

  always_comb begin
    unique case (stage)
      2'd3:    fade_sel = fade3;
      2'd2:    fade_sel = fade2;
      default: fade_sel = fade1;
    endcase
  end

  // table port
  assign wr_idx    = TABLE_BITS'({{TABLE_BITS{1'b0}}, table_address});
  assign mem_we    = in_acc && (mode == MODE_WRITE) && (table_select < TABLE_COUNT);
  assign mem_waddr = {table_select[TSEL_W-1:0], wr_idx};
  assign mem_re    = t_ok && ((state == S_RD_A) || (state == S_RD_B));
  assign mem_raddr = {t[TSEL_W-1:0], (state == S_RD_A) ? idx0 : idx1};

  // blend request
  always_comb begin
    breq.start = 1'b0;
    breq.x     = opx;
    breq.y     = v_rd;
    breq.f     = fade_sel;
    if (state == S_RD_W) begin
      breq.start = 1'b1;
      breq.y     = t_ok ? mem_rdata : '0;
      breq.f     = frac;
    end else if (state == S_XB) begin
      breq.start = 1'b1;
    end
  end

  wtoc_table_mem #(
    .TABLE_BITS  (TABLE_BITS),
    .TABLE_COUNT (TABLE_COUNT)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (table_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  wtoc_blend_unit u_blend (
    .clk (clk),
    .rst (rst),
    .req (breq),
    .rsp (brsp)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dimensions       <= '0;
      start_phase_step <= '0;
      chirp_step       <= '0;
      fade1_start      <= FADE_ONE;
      fade1_step       <= '0;
      fade2_step       <= '0;
      fade3_step       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIMENSIONS:  dimensions       <= cfg_data[1:0];
        REG_START_STEP:  start_phase_step <= cfg_data;
        REG_CHIRP_STEP:  chirp_step       <= cfg_data;
        REG_FADE1_START: fade1_start      <= cfg_data[FADE_W-1:0];
        REG_FADE1_STEP:  fade1_step       <= cfg_data[STEP_W-1:0];
        REG_FADE2_STEP:  fade2_step       <= cfg_data[STEP_W-1:0];
        REG_FADE3_STEP:  fade3_step       <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, oscillator state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      t          <= '0;
      stage      <= '0;
      p          <= '0;
      out_valid  <= 1'b0;
      phase_acc  <= '0;
      phase_step <= '0;
      fade1      <= FADE_ONE;
      fade2      <= '0;
      fade3      <= '0;
    end else begin
      // S_OUT reloads the output register itself
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (mode == MODE_SAMPLE) begin
              t     <= '0;
              state <= S_RD_A;
            end else if (mode == MODE_RESTART) begin
              phase_acc  <= '0;
              phase_step <= start_phase_step;
              fade1      <= (fade1_start > FADE_ONE) ? FADE_ONE : fade1_start;
              fade2      <= '0;
              fade3      <= '0;
            end
          end
        end
        S_RD_A:  state <= S_RD_B;
        S_RD_B:  state <= S_RD_W;
        S_RD_W:  state <= S_IWAIT;
        S_IWAIT: begin
          if (brsp.done) begin
            if (t == n_last) begin
              stage <= dimensions;
              p     <= '0;
              state <= (dimensions == 2'd0) ? S_OUT : S_XA;
            end else begin
              t     <= t + 3'd1;
              state <= S_RD_A;
            end
          end
        end
        S_XA:    state <= S_XB;
        S_XB:    state <= S_XWAIT;
        S_XWAIT: begin
          if (brsp.done) begin
            if (p == half_last) begin
              p <= '0;
              if (stage == 2'd1) begin
                state <= S_OUT;
              end else begin
                stage <= stage - 2'd1;
                state <= S_XA;
              end
            end else begin
              p     <= p + 2'd1;
              state <= S_XA;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (dimensions == 2'd3) begin
              fade3 <= fade_advance(fade3, fade3_step);
            end
            if (dimensions >= 2'd2) begin
              fade2 <= fade_advance(fade2, fade2_step);
            end
            if (dimensions >= 2'd1) begin
              fade1 <= fade_advance(fade1, fade1_step);
            end
            phase_acc  <= phase_acc + phase_step;
            phase_step <= phase_step + chirp_step;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (state == S_RD_B) begin
      opx <= t_ok ? mem_rdata : '0;
    end
    if (state == S_XA) begin
      opx <= v_rd;
    end
    if (state == S_IWAIT && brsp.done) begin
      v[t] <= brsp.value;
    end
    if (state == S_XWAIT && brsp.done) begin
      v[{1'b0, p}] <= brsp.value;
    end
    if (state == S_OUT && out_free) begin
      sample <= v[0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wtoc_table_mem.sv -----
// ----------------------------------------------------------------------------
// wtoc_table_mem
// Wavetable store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wtoc_table_mem #(
  parameter int TABLE_BITS  = wtoc_pkg::TABLE_BITS_DEF,
  parameter int TABLE_COUNT = wtoc_pkg::TABLE_COUNT_DEF,
  parameter int TSEL_W      = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1,
  parameter int ADDR_W      = TSEL_W + TABLE_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [ADDR_W-1:0]                    waddr,
  input  wire logic signed [wtoc_pkg::SAMPLE_W-1:0] wdata,
  input  wire logic                                 re,
  input  wire logic [ADDR_W-1:0]                    raddr,
  output      logic signed [wtoc_pkg::SAMPLE_W-1:0] rdata
);
  import wtoc_pkg::*;

  localparam int DEPTH = TABLE_COUNT << TABLE_BITS;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wtoc_blend_unit.sv -----
// ----------------------------------------------------------------------------
// wtoc_blend_unit
// Shared three-stage blend: x + floor((y - x) * f / 2^16), f in Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

module wtoc_blend_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire wtoc_pkg::blend_req_t req,
  output      wtoc_pkg::blend_rsp_t rsp
);
  import wtoc_pkg::*;

  logic                       v1, v2, v3;
  logic signed [SAMPLE_W:0]   diff;
  logic        [FADE_W-1:0]   f_r;
  logic signed [SAMPLE_W-1:0] x_r1, x_r2;
  logic        [SAMPLE_W-1:0] prod_hi;
  logic signed [SAMPLE_W-1:0] result;
  logic signed [34:0]         prod_full;

  assign prod_full = diff * $signed({1'b0, f_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= req.start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    diff    <= {req.y[SAMPLE_W-1], req.y} - {req.x[SAMPLE_W-1], req.x};
    f_r     <= req.f;
    x_r1    <= req.x;
    // low 16 bits of the floor-shifted product
    prod_hi <= prod_full[31:16];
    x_r2    <= x_r1;
    result  <= x_r2 + $signed(prod_hi);
  end

  assign rsp.done  = v3;
  assign rsp.value = result;

endmodule

`default_nettype wire

// ----- rtl/wtoc_checker.sv -----
// ----------------------------------------------------------------------------
// wtoc_checker
// Port-level checks of the wavetable oscillator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wtoc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  mode,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] sample
);
  import wtoc_pkg::*;

  // a held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample))
    else $error("output word changed while stalled");

  // a sample word occupies the sequencer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode == MODE_SAMPLE |=> in_stall)
    else $error("input not stalled after a sample word");

  // writes, restarts and unknown words leave the input unstalled
  a_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode != MODE_SAMPLE |=> !in_stall)
    else $error("input stalled after a non-sample word");

  // a new output word only comes out of a busy sequencer
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("output word without a sample in progress");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind wavetable_oscillator_crossfade wtoc_checker u_wtoc_checker (.*);

`default_nettype wire
